@@ rtl/mic_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mic_pkg
// Shared types and constants of the MIPS I integer step core.
// ----------------------------------------------------------------------------
package mic_pkg;

    localparam logic [31:0] RESET_PC    = 32'hbfc00000;
    localparam logic [31:0] JUNK_VALUE  = 32'hdeadc0de;
    localparam logic [31:0] ISOLATE_BIT = 32'h00010000;
    localparam logic [31:0] REGION_MASK = 32'hf0000000;
    localparam logic [31:0] SIGN_BIT    = 32'h80000000;
    localparam logic [31:0] ALL_ONES    = 32'hffffffff;

    // bus operations
    localparam logic [2:0] BUS_NONE   = 3'd0;
    localparam logic [2:0] BUS_RD_W   = 3'd1;
    localparam logic [2:0] BUS_RD_B   = 3'd2;
    localparam logic [2:0] BUS_WR_W   = 3'd3;
    localparam logic [2:0] BUS_WR_H   = 3'd4;
    localparam logic [2:0] BUS_WR_B   = 3'd5;

    // fault codes
    localparam logic [2:0] FLT_OK     = 3'd0;
    localparam logic [2:0] FLT_OPCODE = 3'd1;
    localparam logic [2:0] FLT_OVF    = 3'd2;
    localparam logic [2:0] FLT_HALF   = 3'd3;
    localparam logic [2:0] FLT_COP0   = 3'd4;

    // pending load kinds
    localparam logic [2:0] LD_NONE    = 3'd0;
    localparam logic [2:0] LD_WORD    = 3'd1;
    localparam logic [2:0] LD_SBYTE   = 3'd2;
    localparam logic [2:0] LD_UBYTE   = 3'd3;
    localparam logic [2:0] LD_VALUE   = 3'd4;

    // divide request
    localparam logic [1:0] DV_NONE    = 2'd0;
    localparam logic [1:0] DV_SIGNED  = 2'd1;
    localparam logic [1:0] DV_UNSIGN  = 2'd2;

    // primary opcodes
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_REGIMM  = 6'h01;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_BLEZ    = 6'h06;
    localparam logic [5:0] OP_BGTZ    = 6'h07;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0a;
    localparam logic [5:0] OP_SLTIU   = 6'h0b;
    localparam logic [5:0] OP_ANDI    = 6'h0c;
    localparam logic [5:0] OP_ORI     = 6'h0d;
    localparam logic [5:0] OP_LUI     = 6'h0f;
    localparam logic [5:0] OP_COP0    = 6'h10;
    localparam logic [5:0] OP_LB      = 6'h20;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_LBU     = 6'h24;
    localparam logic [5:0] OP_SB      = 6'h28;
    localparam logic [5:0] OP_SH      = 6'h29;
    localparam logic [5:0] OP_SW      = 6'h2b;

    // SPECIAL functions
    localparam logic [5:0] FN_SLL     = 6'h00;
    localparam logic [5:0] FN_SRL     = 6'h02;
    localparam logic [5:0] FN_SRA     = 6'h03;
    localparam logic [5:0] FN_JR      = 6'h08;
    localparam logic [5:0] FN_JALR    = 6'h09;
    localparam logic [5:0] FN_MFHI    = 6'h10;
    localparam logic [5:0] FN_MFLO    = 6'h12;
    localparam logic [5:0] FN_DIV     = 6'h1a;
    localparam logic [5:0] FN_DIVU    = 6'h1b;
    localparam logic [5:0] FN_ADD     = 6'h20;
    localparam logic [5:0] FN_ADDU    = 6'h21;
    localparam logic [5:0] FN_SUBU    = 6'h23;
    localparam logic [5:0] FN_AND     = 6'h24;
    localparam logic [5:0] FN_OR      = 6'h25;
    localparam logic [5:0] FN_SLTU    = 6'h2b;

    // COP0 sub-ops
    localparam logic [4:0] CP_MF      = 5'h00;
    localparam logic [4:0] CP_MT      = 5'h04;

    typedef struct packed {
        logic [31:0] fetched_word;
        logic [31:0] load_data;
    } t_in_item;

    typedef struct packed {
        logic [31:0] fetch_address;
        logic [2:0]  bus_op;
        logic [31:0] bus_address;
        logic [31:0] bus_write_data;
        logic [2:0]  fault_code;
    } t_out_item;

    // decoded effect of one instruction, faults already applied
    typedef struct packed {
        logic        wr;
        logic [4:0]  wr_idx;
        logic [31:0] wr_val;
        logic [31:0] new_pc;
        logic [2:0]  bop;
        logic [31:0] baddr;
        logic [31:0] bdata;
        logic [2:0]  fault;
        logic [2:0]  np_kind;
        logic [4:0]  np_target;
        logic [31:0] np_value;
        logic        st_we;
        logic [31:0] st_val;
        logic [1:0]  div_kind;
    } t_exec;

endpackage
`default_nettype wire

@@ rtl/mic_regfile.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mic_regfile
// 32x32 register file, one write and two registered reads, valid bits.
// ----------------------------------------------------------------------------
module mic_regfile
    import mic_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_we,
    input  wire logic [4:0]  i_waddr,
    input  wire logic [31:0] i_wdata,
    input  wire logic        i_re,
    input  wire logic [4:0]  i_raddr_a,
    input  wire logic [4:0]  i_raddr_b,
    output logic      [31:0] o_rdata_a,
    output logic      [31:0] o_rdata_b
);

    logic [31:0] r_mem [32];
    logic [31:0] r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we && i_waddr != 5'd0) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we && i_waddr != 5'd0) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // unwritten entries read as the reset pattern, r0 as zero
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_a <= (i_raddr_a == 5'd0) ? 32'd0 :
                         (r_valid[i_raddr_a] ? r_mem[i_raddr_a] : JUNK_VALUE);
            o_rdata_b <= (i_raddr_b == 5'd0) ? 32'd0 :
                         (r_valid[i_raddr_b] ? r_mem[i_raddr_b] : JUNK_VALUE);
        end
    end

endmodule
`default_nettype wire

@@ rtl/mic_divider.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mic_divider
// Unsigned restoring divider, one quotient bit per cycle, 32 steps.
// ----------------------------------------------------------------------------
module mic_divider
    import mic_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_num,
    input  wire logic [31:0] i_den,
    output logic             o_done,
    output logic      [31:0] o_quo,
    output logic      [31:0] o_rem
);

    logic        r_busy;
    logic [4:0]  r_cnt;
    logic [31:0] r_den;
    logic [32:0] w_shift;
    logic [32:0] w_diff;

    assign w_shift = {o_rem, o_quo[31]};
    assign w_diff  = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            o_quo <= i_num;
            o_rem <= '0;
        end else if (r_busy) begin
            if (!w_diff[32]) begin
                o_rem <= w_diff[31:0];
            end else begin
                o_rem <= w_shift[31:0];
            end
            o_quo <= {o_quo[30:0], ~w_diff[32]};
        end
    end

endmodule
`default_nettype wire

@@ rtl/mic_exec.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mic_exec
// Instruction decode and execute: next PC, write back, bus access, faults.
// ----------------------------------------------------------------------------
module mic_exec
    import mic_pkg::*;
(
    input  wire logic [31:0] i_ir,
    input  wire logic [31:0] i_pc,
    input  wire logic [31:0] i_vs,
    input  wire logic [31:0] i_vt,
    input  wire logic [31:0] i_hi,
    input  wire logic [31:0] i_lo,
    input  wire logic [31:0] i_status,
    output t_exec            o_ex
);

    logic [5:0]  w_op, w_fn;
    logic [4:0]  w_rs, w_rt, w_rd, w_sh;
    logic [31:0] w_imm, w_ise, w_addr, w_link, w_br, w_jmp, w_sum, w_sumi;
    logic        w_iso, w_ltz;
    t_exec       w_ex;

    assign w_op   = i_ir[31:26];
    assign w_fn   = i_ir[5:0];
    assign w_rs   = i_ir[25:21];
    assign w_rt   = i_ir[20:16];
    assign w_rd   = i_ir[15:11];
    assign w_sh   = i_ir[10:6];
    assign w_imm  = {16'd0, i_ir[15:0]};
    assign w_ise  = {{16{i_ir[15]}}, i_ir[15:0]};
    assign w_addr = i_vs + w_ise;
    assign w_link = i_pc + 32'd4;
    assign w_br   = i_pc + {w_ise[29:0], 2'b00};
    assign w_jmp  = (i_pc & REGION_MASK) | {4'd0, i_ir[25:0], 2'b00};
    assign w_sum  = i_vs + i_vt;
    assign w_sumi = i_vs + w_ise;
    assign w_iso  = (i_status & ISOLATE_BIT) != 32'd0;
    assign w_ltz  = i_vs[31];

    always_comb begin
        w_ex        = '0;
        w_ex.new_pc = w_link;
        unique case (w_op)
            OP_SPECIAL: begin
                w_ex.wr_idx = w_rd;
                unique case (w_fn)
                    FN_SLL:  begin w_ex.wr = 1'b1; w_ex.wr_val = i_vt << w_sh; end
                    FN_SRL:  begin w_ex.wr = 1'b1; w_ex.wr_val = i_vt >> w_sh; end
                    FN_SRA:  begin
                        w_ex.wr = 1'b1;
                        w_ex.wr_val = $unsigned($signed(i_vt) >>> w_sh);
                    end
                    FN_JR:   w_ex.new_pc = i_vs;
                    FN_JALR: begin
                        w_ex.wr = 1'b1; w_ex.wr_val = w_link; w_ex.new_pc = i_vs;
                    end
                    FN_MFHI: begin w_ex.wr = 1'b1; w_ex.wr_val = i_hi; end
                    FN_MFLO: begin w_ex.wr = 1'b1; w_ex.wr_val = i_lo; end
                    FN_DIV:  w_ex.div_kind = DV_SIGNED;
                    FN_DIVU: w_ex.div_kind = DV_UNSIGN;
                    FN_ADD:  begin
                        w_ex.wr_val = w_sum;
                        if (((w_sum ^ i_vs) & (w_sum ^ i_vt) & SIGN_BIT) != 32'd0) begin
                            w_ex.fault = FLT_OVF;
                        end else begin
                            w_ex.wr = 1'b1;
                        end
                    end
                    FN_ADDU: begin w_ex.wr = 1'b1; w_ex.wr_val = w_sum; end
                    FN_SUBU: begin w_ex.wr = 1'b1; w_ex.wr_val = i_vs - i_vt; end
                    FN_AND:  begin w_ex.wr = 1'b1; w_ex.wr_val = i_vs & i_vt; end
                    FN_OR:   begin w_ex.wr = 1'b1; w_ex.wr_val = i_vs | i_vt; end
                    FN_SLTU: begin
                        w_ex.wr = 1'b1; w_ex.wr_val = {31'd0, i_vs < i_vt};
                    end
                    default: w_ex.fault = FLT_OPCODE;
                endcase
            end
            OP_REGIMM: begin
                if (i_ir[20:17] == 4'b1000) begin
                    w_ex.wr = 1'b1; w_ex.wr_idx = 5'd31; w_ex.wr_val = w_link;
                end
                if (i_ir[16] ? !w_ltz : w_ltz) w_ex.new_pc = w_br;
            end
            OP_J:   w_ex.new_pc = w_jmp;
            OP_JAL: begin
                w_ex.wr = 1'b1; w_ex.wr_idx = 5'd31; w_ex.wr_val = w_link;
                w_ex.new_pc = w_jmp;
            end
            OP_BEQ:  if (i_vs == i_vt) w_ex.new_pc = w_br;
            OP_BNE:  if (i_vs != i_vt) w_ex.new_pc = w_br;
            OP_BLEZ: if (w_ltz || i_vs == 32'd0) w_ex.new_pc = w_br;
            OP_BGTZ: if (!w_ltz && i_vs != 32'd0) w_ex.new_pc = w_br;
            OP_ADDI: begin
                w_ex.wr_idx = w_rt; w_ex.wr_val = w_sumi;
                if (((w_sumi ^ i_vs) & (w_sumi ^ w_ise) & SIGN_BIT) != 32'd0) begin
                    w_ex.fault = FLT_OVF;
                end else begin
                    w_ex.wr = 1'b1;
                end
            end
            OP_ADDIU: begin w_ex.wr = 1'b1; w_ex.wr_idx = w_rt; w_ex.wr_val = w_sumi; end
            OP_SLTI: begin
                w_ex.wr = 1'b1; w_ex.wr_idx = w_rt;
                w_ex.wr_val = {31'd0, $signed(i_vs) < $signed(w_ise)};
            end
            OP_SLTIU: begin
                w_ex.wr = 1'b1; w_ex.wr_idx = w_rt; w_ex.wr_val = {31'd0, i_vs < w_ise};
            end
            OP_ANDI: begin w_ex.wr = 1'b1; w_ex.wr_idx = w_rt; w_ex.wr_val = i_vs & w_imm; end
            OP_ORI:  begin w_ex.wr = 1'b1; w_ex.wr_idx = w_rt; w_ex.wr_val = i_vs | w_imm; end
            OP_LUI:  begin
                w_ex.wr = 1'b1; w_ex.wr_idx = w_rt; w_ex.wr_val = {i_ir[15:0], 16'd0};
            end
            OP_COP0: begin
                if (w_rs == CP_MF) begin
                    if (w_rd == 5'd12) begin
                        w_ex.np_kind = LD_VALUE; w_ex.np_target = w_rt;
                        w_ex.np_value = i_status;
                    end else begin
                        w_ex.fault = FLT_COP0;
                    end
                end else if (w_rs == CP_MT) begin
                    case (w_rd) inside
                        5'd3, 5'd5, 5'd6, 5'd7, 5'd9, 5'd11, 5'd13: begin
                            if (i_vt != 32'd0) w_ex.fault = FLT_COP0;
                        end
                        5'd12: begin w_ex.st_we = 1'b1; w_ex.st_val = i_vt; end
                        default: w_ex.fault = FLT_COP0;
                    endcase
                end else begin
                    w_ex.fault = FLT_OPCODE;
                end
            end
            OP_LB: begin
                w_ex.bop = BUS_RD_B; w_ex.baddr = w_addr;
                w_ex.np_kind = LD_SBYTE; w_ex.np_target = w_rt;
            end
            OP_LBU: begin
                w_ex.bop = BUS_RD_B; w_ex.baddr = w_addr;
                w_ex.np_kind = LD_UBYTE; w_ex.np_target = w_rt;
            end
            OP_LW: if (!w_iso) begin
                w_ex.bop = BUS_RD_W; w_ex.baddr = w_addr;
                w_ex.np_kind = LD_WORD; w_ex.np_target = w_rt;
            end
            OP_SB: if (!w_iso) begin
                w_ex.bop = BUS_WR_B; w_ex.baddr = w_addr; w_ex.bdata = {24'd0, i_vt[7:0]};
            end
            OP_SH: begin
                if (w_addr[0]) begin
                    w_ex.fault = FLT_HALF;
                end else if (!w_iso) begin
                    w_ex.bop = BUS_WR_H; w_ex.baddr = w_addr;
                    w_ex.bdata = {16'd0, i_vt[15:0]};
                end
            end
            OP_SW: if (!w_iso) begin
                w_ex.bop = BUS_WR_W; w_ex.baddr = w_addr; w_ex.bdata = i_vt;
            end
            default: w_ex.fault = FLT_OPCODE;
        endcase

        // a faulting instruction keeps only its PC advance
        if (w_ex.fault != FLT_OK) begin
            w_ex.wr = 1'b0; w_ex.bop = BUS_NONE; w_ex.baddr = '0; w_ex.bdata = '0;
            w_ex.np_kind = LD_NONE; w_ex.np_target = '0; w_ex.np_value = '0;
            w_ex.st_we = 1'b0; w_ex.div_kind = DV_NONE;
        end
        o_ex = w_ex;
    end

endmodule
`default_nettype wire

@@ rtl/mips_integer_core_step.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mips_integer_core_step
// MIPS I integer core advanced by one instruction per input item.
// ----------------------------------------------------------------------------
//  channel  | signals                               | carries
//  ---------+---------------------------------------+--------------------------
//  in       | i_in_valid, o_in_stall, i_in_item     | fetched word, load data
//  out      | o_out_valid, i_out_stall, o_out_item  | fetch addr, bus op, fault
//
//  Steps: an item is taken in idle, then passes read, execute and write back;
//  DIV and DIVU with a nonzero divisor add a wait on the bit-serial divider.
//  The two register file writes (landing load, then the instruction's own
//  write) use its single write port in separate cycles, execute and commit.
//  Reset: synchronous active-low; the register file valid bits clear at once.
//  Stalls: a finished item waits in the output register; the next item is
//  taken meanwhile and holds in write back until the output register frees.
// ----------------------------------------------------------------------------
module mips_integer_core_step
    import mic_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_item
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_EXEC = 5'b00100,
        S_DIV  = 5'b01000,
        S_WB   = 5'b10000
    } t_state;

    t_state      r_state;

    // architectural state
    logic [31:0] r_pc, r_ir, r_hi, r_lo, r_status;
    logic [2:0]  r_pk;
    logic [4:0]  r_pt;
    logic [31:0] r_pv;

    // per-item holding registers
    t_in_item    r_in;
    t_exec       r_ex;
    logic [31:0] r_vs;
    logic        r_vt_neg;
    logic        r_dzero;

    logic [31:0] w_vs, w_vt, w_land_val, w_quo, w_rem, w_hi, w_lo;
    logic        w_land, w_div_done, w_div_start, w_commit;
    logic        w_we;
    logic [4:0]  w_waddr;
    logic [31:0] w_wdata;
    t_exec       w_ex;

    mic_regfile u_rf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_re      (r_state == S_READ),
        .i_raddr_a (r_ir[25:21]),
        .i_raddr_b (r_ir[20:16]),
        .o_rdata_a (w_vs),
        .o_rdata_b (w_vt)
    );

    mic_exec u_exec (
        .i_ir     (r_ir),
        .i_pc     (r_pc),
        .i_vs     (w_vs),
        .i_vt     (w_vt),
        .i_hi     (r_hi),
        .i_lo     (r_lo),
        .i_status (r_status),
        .o_ex     (w_ex)
    );

    // divider sees magnitudes; signs are restored at write back
    assign w_div_start = (r_state == S_EXEC) && (w_ex.div_kind != DV_NONE)
                         && (w_vt != 32'd0);

    mic_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   ((w_ex.div_kind == DV_SIGNED && w_vs[31]) ? (32'd0 - w_vs) : w_vs),
        .i_den   ((w_ex.div_kind == DV_SIGNED && w_vt[31]) ? (32'd0 - w_vt) : w_vt),
        .o_done  (w_div_done),
        .o_quo   (w_quo),
        .o_rem   (w_rem)
    );

    // landing value of the pending load
    always_comb begin
        w_land     = 1'b1;
        w_land_val = '0;
        case (r_pk)
            LD_WORD:  w_land_val = r_in.load_data;
            LD_SBYTE: w_land_val = {{24{r_in.load_data[7]}}, r_in.load_data[7:0]};
            LD_UBYTE: w_land_val = {24'd0, r_in.load_data[7:0]};
            LD_VALUE: w_land_val = r_pv;
            default:  w_land = 1'b0;
        endcase
    end

    // HI/LO after a divide
    always_comb begin
        w_hi = r_hi;
        w_lo = r_lo;
        if (r_ex.div_kind != DV_NONE) begin
            if (r_dzero) begin
                w_hi = r_vs;
                w_lo = (r_ex.div_kind == DV_SIGNED && r_vs[31]) ? 32'd1 : ALL_ONES;
            end else if (r_ex.div_kind == DV_SIGNED) begin
                w_hi = r_vs[31] ? (32'd0 - w_rem) : w_rem;
                w_lo = (r_vs[31] != r_vt_neg) ? (32'd0 - w_quo) : w_quo;
            end else begin
                w_hi = w_rem;
                w_lo = w_quo;
            end
        end
    end

    assign w_commit = (r_state == S_WB) && (!o_out_valid || !i_out_stall);

    // single write port: landing load in execute, own write at commit
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_pt;
        w_wdata = w_land_val;
        if (r_state == S_EXEC) begin
            w_we = w_land;
        end else if (w_commit) begin
            w_we    = r_ex.wr;
            w_waddr = r_ex.wr_idx;
            w_wdata = r_ex.wr_val;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= RESET_PC;
            r_ir        <= '0;
            r_hi        <= JUNK_VALUE;
            r_lo        <= JUNK_VALUE;
            r_status    <= '0;
            r_pk        <= LD_NONE;
            r_pt        <= '0;
            r_pv        <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (w_commit) begin
                o_out_valid <= 1'b1;
            end else if (o_out_valid && !i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: if (i_in_valid) r_state <= S_READ;
                S_READ: r_state <= S_EXEC;
                S_EXEC: r_state <= w_div_start ? S_DIV : S_WB;
                S_DIV:  if (w_div_done) r_state <= S_WB;
                S_WB: begin
                    if (w_commit) begin
                        r_state     <= S_IDLE;
                        r_pc        <= r_ex.new_pc;
                        r_ir        <= r_in.fetched_word;
                        r_hi        <= w_hi;
                        r_lo        <= w_lo;
                        if (r_ex.st_we) r_status <= r_ex.st_val;
                        r_pk        <= r_ex.np_kind;
                        r_pt        <= r_ex.np_target;
                        r_pv        <= r_ex.np_value;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) r_in <= i_in_item;
        if (r_state == S_EXEC) begin
            r_ex     <= w_ex;
            r_vs     <= w_vs;
            r_vt_neg <= w_vt[31];
            r_dzero  <= (w_vt == 32'd0);
        end
        if (w_commit) begin
            o_out_item.fetch_address  <= r_ex.new_pc;
            o_out_item.bus_op         <= r_ex.bop;
            o_out_item.bus_address    <= r_ex.baddr;
            o_out_item.bus_write_data <= r_ex.bdata;
            o_out_item.fault_code     <= r_ex.fault;
        end
    end

`ifndef NO_ASSERTIONS
    a_fault_no_bus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.fault_code != FLT_OK |-> o_out_item.bus_op == BUS_NONE)
        else $error("faulting item drives a bus access");
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == S_DIV)
        else $error("divider finished outside divide state");
    a_commit_sets_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> o_out_valid && r_state == S_IDLE)
        else $error("commit did not deliver an item");
`endif

endmodule
`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for mips_integer_core_step. A directed instruction
// sequence (faults, loads, stores, divide corner cases, cache isolate, links)
// is followed by random instruction streams under varying idle and stall
// patterns. Each accepted item is run through an in-bench model of the core.
// Each result is compared field by field against the oldest predicted one.
// ----------------------------------------------------------------------------
module tb;
    import mic_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 100;  // margin for one item with a divide
    localparam int RAND_PER_PHASE = 325;

    typedef struct {
        logic [31:0] word;
        logic [31:0] ld;
        logic        typed;   // typed-in bus/fault fields replace the model's
        logic [2:0]  bop;
        logic [31:0] badr;
        logic [31:0] bdat;
        logic [2:0]  flt;
    } t_dir_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_item  in_item = '0;
    logic      out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;

    mips_integer_core_step DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out_item (o_out_item)
    );

    // model state of the core
    logic [31:0] gpr [32];
    logic [31:0] pc_q, held_q, lo_q, hi_q, sr_q, pend_val;
    logic [4:0]  pend_tgt;
    logic [2:0]  pend_kind;

    t_out_item   result_q [$];
    t_dir_row    dir_tab [25];
    int          errors = 0;
    int          idle_pct = 0;     // sender idle chance, percent
    int          stall_pct = 0;    // receiver stall chance, percent
    bit          hold_req = 1'b0;  // ask for a long receiver hold-off
    int          quiet_cycles = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // model of one instruction step
    // ------------------------------------------------------------------
    task automatic core_reset();
        gpr[0] = '0;
        for (int i = 1; i < 32; i++) gpr[i] = JUNK_VALUE;
        pc_q = RESET_PC; held_q = '0;
        lo_q = JUNK_VALUE; hi_q = JUNK_VALUE; sr_q = '0;
        pend_tgt = '0; pend_kind = LD_NONE; pend_val = '0;
    endtask

    task automatic core_step(input t_in_item it, output t_out_item r);
        logic [31:0] w, slot, vs, vt, ise, addr, npc, wv, lv, bad, bdt, npv;
        logic [5:0]  op, fn;
        logic [4:0]  rs, rt, rd, sa, widx, npt;
        logic [2:0]  bop, flt, npk;
        logic        wr, land, iso;
        w = held_q; slot = pc_q;
        op = w[31:26]; fn = w[5:0];
        rs = w[25:21]; rt = w[20:16]; rd = w[15:11]; sa = w[10:6];
        ise = {{16{w[15]}}, w[15:0]};
        vs = gpr[rs]; vt = gpr[rt];
        addr = vs + ise;
        iso = (sr_q & ISOLATE_BIT) != 0;
        wr = 1'b0; widx = '0; wv = '0; land = 1'b1; lv = '0;
        bop = BUS_NONE; bad = '0; bdt = '0; flt = FLT_OK;
        npk = LD_NONE; npt = '0; npv = '0;
        held_q = it.fetched_word;
        npc = slot + 4;

        case (pend_kind)
            LD_WORD:  lv = it.load_data;
            LD_SBYTE: lv = {{24{it.load_data[7]}}, it.load_data[7:0]};
            LD_UBYTE: lv = {24'd0, it.load_data[7:0]};
            LD_VALUE: lv = pend_val;
            default:  land = 1'b0;
        endcase

        case (op)
            OP_SPECIAL: begin
                case (fn)
                    FN_SLL:  begin wr = 1; widx = rd; wv = vt << sa; end
                    FN_SRL:  begin wr = 1; widx = rd; wv = vt >> sa; end
                    FN_SRA:  begin wr = 1; widx = rd; wv = $signed(vt) >>> sa; end
                    FN_JR:   npc = vs;
                    FN_JALR: begin wr = 1; widx = rd; wv = slot + 4; npc = vs; end
                    FN_MFHI: begin wr = 1; widx = rd; wv = hi_q; end
                    FN_MFLO: begin wr = 1; widx = rd; wv = lo_q; end
                    FN_DIV: begin
                        if (vt == 0) begin
                            hi_q = vs; lo_q = vs[31] ? 32'd1 : ALL_ONES;
                        end else if (vs == SIGN_BIT && vt == ALL_ONES) begin
                            hi_q = '0; lo_q = SIGN_BIT;
                        end else begin
                            // SV signed divide truncates toward zero
                            lo_q = $signed(vs) / $signed(vt);
                            hi_q = $signed(vs) % $signed(vt);
                        end
                    end
                    FN_DIVU: begin
                        if (vt == 0) begin
                            hi_q = vs; lo_q = ALL_ONES;
                        end else begin
                            hi_q = vs % vt; lo_q = vs / vt;
                        end
                    end
                    FN_ADD: begin
                        wv = vs + vt;
                        if (((wv ^ vs) & (wv ^ vt) & SIGN_BIT) != 0) flt = FLT_OVF;
                        else begin wr = 1; widx = rd; end
                    end
                    FN_ADDU: begin wr = 1; widx = rd; wv = vs + vt; end
                    FN_SUBU: begin wr = 1; widx = rd; wv = vs - vt; end
                    FN_AND:  begin wr = 1; widx = rd; wv = vs & vt; end
                    FN_OR:   begin wr = 1; widx = rd; wv = vs | vt; end
                    FN_SLTU: begin wr = 1; widx = rd; wv = (vs < vt) ? 1 : 0; end
                    default: flt = FLT_OPCODE;
                endcase
            end
            OP_REGIMM: begin
                // link on rt = 1000x whether taken or not
                if (w[20:17] == 4'd8) begin wr = 1; widx = 5'd31; wv = slot + 4; end
                if (w[16] ? !vs[31] : vs[31]) npc = slot + (ise << 2);
            end
            OP_J:    npc = (slot & REGION_MASK) | {4'd0, w[25:0], 2'd0};
            OP_JAL: begin
                wr = 1; widx = 5'd31; wv = slot + 4;
                npc = (slot & REGION_MASK) | {4'd0, w[25:0], 2'd0};
            end
            OP_BEQ:  if (vs == vt) npc = slot + (ise << 2);
            OP_BNE:  if (vs != vt) npc = slot + (ise << 2);
            OP_BLEZ: if (vs[31] || vs == 0) npc = slot + (ise << 2);
            OP_BGTZ: if (!vs[31] && vs != 0) npc = slot + (ise << 2);
            OP_ADDI: begin
                wv = vs + ise;
                if (((wv ^ vs) & (wv ^ ise) & SIGN_BIT) != 0) flt = FLT_OVF;
                else begin wr = 1; widx = rt; end
            end
            OP_ADDIU: begin wr = 1; widx = rt; wv = vs + ise; end
            OP_SLTI:  begin wr = 1; widx = rt; wv = ($signed(vs) < $signed(ise)) ? 1 : 0; end
            OP_SLTIU: begin wr = 1; widx = rt; wv = (vs < ise) ? 1 : 0; end
            OP_ANDI:  begin wr = 1; widx = rt; wv = vs & {16'd0, w[15:0]}; end
            OP_ORI:   begin wr = 1; widx = rt; wv = vs | {16'd0, w[15:0]}; end
            OP_LUI:   begin wr = 1; widx = rt; wv = {w[15:0], 16'd0}; end
            OP_COP0: begin
                if (rs == CP_MF) begin
                    if (rd == 5'd12) begin npk = LD_VALUE; npt = rt; npv = sr_q; end
                    else flt = FLT_COP0;
                end else if (rs == CP_MT) begin
                    case (rd)
                        5'd3, 5'd5, 5'd6, 5'd7, 5'd9, 5'd11, 5'd13:
                            if (vt != 0) flt = FLT_COP0;
                        5'd12:   sr_q = vt;
                        default: flt = FLT_COP0;
                    endcase
                end else begin
                    flt = FLT_OPCODE;
                end
            end
            OP_LB:  begin bop = BUS_RD_B; bad = addr; npk = LD_SBYTE; npt = rt; end
            OP_LBU: begin bop = BUS_RD_B; bad = addr; npk = LD_UBYTE; npt = rt; end
            OP_LW:  if (!iso) begin bop = BUS_RD_W; bad = addr; npk = LD_WORD; npt = rt; end
            OP_SB:  if (!iso) begin bop = BUS_WR_B; bad = addr; bdt = vt & 32'hff; end
            OP_SH: begin
                if (addr[0]) flt = FLT_HALF;
                else if (!iso) begin bop = BUS_WR_H; bad = addr; bdt = vt & 32'hffff; end
            end
            OP_SW:  if (!iso) begin bop = BUS_WR_W; bad = addr; bdt = vt; end
            default: flt = FLT_OPCODE;
        endcase

        // landing load first, then the instruction's own write
        if (land) gpr[pend_tgt] = lv;
        pend_kind = LD_NONE; pend_tgt = '0; pend_val = '0;
        if (flt == FLT_OK) begin
            if (wr) gpr[widx] = wv;
            pend_kind = npk; pend_tgt = npt; pend_val = npv;
        end else begin
            bop = BUS_NONE; bad = '0; bdt = '0;
        end
        gpr[0] = '0;
        pc_q = npc;
        r.fetch_address = npc;
        r.bus_op = bop;
        r.bus_address = bad;
        r.bus_write_data = bdt;
        r.fault_code = flt;
    endtask

    // ------------------------------------------------------------------
    // random instruction words
    // ------------------------------------------------------------------
    function automatic logic [4:0] pick_reg();
        // mostly a small register set so results feed later instructions
        return ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(7));
    endfunction

    function automatic logic [31:0] rand_insn();
        logic [31:0] w;
        logic [5:0]  op, fn;
        logic [4:0]  rs, rd;
        int          r;
        r = $urandom_range(99);
        w = $urandom;
        if (r < 8) return w;  // noise, mostly unknown opcodes
        w[25:21] = pick_reg();
        w[20:16] = pick_reg();
        if ($urandom_range(1)) w[15:0] = 16'($signed($urandom_range(16)) - 8);
        if (r < 42) begin
            case ($urandom_range(15))
                0: fn = FN_SLL;   1: fn = FN_SRL;   2: fn = FN_SRA;   3: fn = FN_JR;
                4: fn = FN_JALR;  5: fn = FN_MFHI;  6: fn = FN_MFLO;  7: fn = FN_DIV;
                8: fn = FN_DIVU;  9: fn = FN_ADD;  10: fn = FN_ADDU; 11: fn = FN_SUBU;
               12: fn = FN_AND;  13: fn = FN_OR;   14: fn = FN_SLTU;
               default: fn = 6'($urandom_range(63));
            endcase
            w[15:11] = pick_reg();
            w[31:26] = OP_SPECIAL; w[5:0] = fn;
        end else if (r < 50) begin
            case ($urandom_range(3))
                0, 1: rs = CP_MT;
                2: rs = CP_MF;
                default: rs = 5'($urandom_range(31));
            endcase
            case ($urandom_range(3))
                0, 1: rd = 5'd12;
                2: rd = 5'd3;
                default: rd = 5'($urandom_range(31));
            endcase
            w[31:26] = OP_COP0; w[25:21] = rs; w[15:11] = rd;
        end else begin
            case ($urandom_range(20))
                0: op = OP_REGIMM;  1: op = OP_J;      2: op = OP_JAL;    3: op = OP_BEQ;
                4: op = OP_BNE;     5: op = OP_BLEZ;   6: op = OP_BGTZ;   7: op = OP_ADDI;
                8: op = OP_ADDIU;   9: op = OP_SLTI;  10: op = OP_SLTIU; 11: op = OP_ANDI;
               12: op = OP_ORI;    13: op = OP_LUI;   14: op = OP_LB;    15: op = OP_LW;
               16: op = OP_LBU;    17: op = OP_SB;    18: op = OP_SH;
               default: op = OP_SW;
            endcase
            w[31:26] = op;
        end
        return w;
    endfunction

    // ------------------------------------------------------------------
    // sender: offer one item, hold it until accepted, then predict
    // ------------------------------------------------------------------
    task automatic send_item(input t_in_item it, input bit typed, input t_out_item typed_res);
        t_out_item pred;
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        core_step(it, pred);
        if (typed) begin
            // next address still from the model, the rest is typed in
            typed_res.fetch_address = pred.fetch_address;
            pred = typed_res;
        end
        result_q.push_back(pred);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (exp_v !== got_v) begin
            $display("%0t: %s expected %h got %h", $time, name, exp_v, got_v);
            errors++;
        end
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            if (hold_req) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            out_stall <= ($urandom_range(99) < stall_pct);
            @(posedge i_clk);
        end
    end

    // result checker and watchdog
    always @(posedge i_clk) begin
        t_out_item exp_r;
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (result_q.size() == 0) begin
                $display("%0t: result with none expected, got %p", $time, o_out_item);
                errors++;
            end else begin
                exp_r = result_q.pop_front();
                check_field("fetch_address", exp_r.fetch_address, o_out_item.fetch_address);
                check_field("bus_op", 32'(exp_r.bus_op), 32'(o_out_item.bus_op));
                check_field("bus_address", exp_r.bus_address, o_out_item.bus_address);
                check_field("bus_write_data", exp_r.bus_write_data,
                            o_out_item.bus_write_data);
                check_field("fault_code", 32'(exp_r.fault_code), 32'(o_out_item.fault_code));
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        t_in_item  it;
        t_out_item tr;
        // each row's typed result is that of the word one row above it
        dir_tab[0]  = '{32'h3c018000, 32'h0,        1, BUS_NONE, 32'h0, 32'h0, FLT_OK};
        dir_tab[1]  = '{32'h2022ffff, 32'h0,        0, BUS_NONE, 32'h0, 32'h0, FLT_OK};
        dir_tab[2]  = '{32'h00212020, 32'h0,        1, BUS_NONE, 32'h0, 32'h0, FLT_OVF};
        dir_tab[3]  = '{32'hfc000000, 32'h0,        1, BUS_NONE, 32'h0, 32'h0, FLT_OVF};
        dir_tab[4]  = '{32'ha4000001, 32'h0,        1, BUS_NONE, 32'h0, 32'h0, FLT_OPCODE};
        dir_tab[5]  = '{32'h40002800, 32'h0,        1, BUS_NONE, 32'h0, 32'h0, FLT_HALF};
        dir_tab[6]  = '{32'hac010004, 32'h0,        1, BUS_NONE, 32'h0, 32'h0, FLT_COP0};
        dir_tab[7]  = '{32'h8c050000, 32'h0,        1, BUS_WR_W, 32'h4, SIGN_BIT, FLT_OK};
        dir_tab[8]  = '{32'h8006ffff, ALL_ONES,     1, BUS_RD_W, 32'h0, 32'h0, FLT_OK};
        dir_tab[9]  = '{32'h90070000, 32'h00000080, 1, BUS_RD_B, ALL_ONES, 32'h0, FLT_OK};
        dir_tab[10] = '{32'h0000001a, 32'h00000080, 1, BUS_RD_B, 32'h0, 32'h0, FLT_OK};
        dir_tab[11] = '{32'h00004812, 32'h0,        0, BUS_NONE, 32'h0, 32'h0, FLT_OK};
        dir_tab[12] = '{32'h00005010, 32'h0,        0, BUS_NONE, 32'h0, 32'h0, FLT_OK};
        dir_tab[13] = '{32'h0020001b, 32'h0,        0, BUS_NONE, 32'h0, 32'h0, FLT_OK};
        dir_tab[14] = '{32'h240bffff, 32'h0,        0, BUS_NONE, 32'h0, 32'h0, FLT_OK};
        dir_tab[15] = '{32'h002b001a, 32'h0,        0, BUS_NONE, 32'h0, 32'h0, FLT_OK};
        dir_tab[16] = '{32'h00006012, 32'h0,        0, BUS_NONE, 32'h0, 32'h0, FLT_OK};
        dir_tab[17] = '{32'h3c0d0001, 32'h0,        0, BUS_NONE, 32'h0, 32'h0, FLT_OK};
        dir_tab[18] = '{32'h408d6000, 32'h0,        0, BUS_NONE, 32'h0, 32'h0, FLT_OK};
        dir_tab[19] = '{32'hac010000, 32'h0,        0, BUS_NONE, 32'h0, 32'h0, FLT_OK};
        dir_tab[20] = '{32'h40801800, 32'h0,        1, BUS_NONE, 32'h0, 32'h0, FLT_OK};
        dir_tab[21] = '{32'h40806000, 32'h0,        1, BUS_NONE, 32'h0, 32'h0, FLT_OK};
        dir_tab[22] = '{32'h04110001, 32'h0,        0, BUS_NONE, 32'h0, 32'h0, FLT_OK};
        dir_tab[23] = '{32'h08000000, 32'h0,        0, BUS_NONE, 32'h0, 32'h0, FLT_OK};
        dir_tab[24] = '{32'h03e00008, 32'h0,        0, BUS_NONE, 32'h0, 32'h0, FLT_OK};

        core_reset();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: overflow, unknown opcode, odd half store, cop0 faults,
        // loads and stores, divide by zero and the min / -1 case, isolate,
        // zero write to a tolerated cop0 register, link and jumps
        foreach (dir_tab[i]) begin
            it.fetched_word = dir_tab[i].word;
            it.load_data    = dir_tab[i].ld;
            tr = '{32'h0, dir_tab[i].bop, dir_tab[i].badr, dir_tab[i].bdat, dir_tab[i].flt};
            send_item(it, dir_tab[i].typed, tr);
        end

        // random: free flow with hold-off, idle sender, stalling receiver, both
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = (ph == 1) ? 63 : (ph == 3) ? 24 : 0;
            stall_pct = (ph == 2) ? 63 : (ph == 3) ? 24 : 0;
            if (ph == 0) hold_req = 1'b1;  // long hold-off while items keep coming
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                it.fetched_word = rand_insn();
                it.load_data    = $urandom;
                send_item(it, 1'b0, '0);
            end
        end
        in_valid <= 1'b0;

        while (result_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

endmodule
